/* rtl/imcs_pkg.sv */
// Shared types, constants and helper functions for the intake mode and color sort controller.
package imcs_pkg;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_REVERSE = 3'd2,
    MODE_HIGH    = 3'd3,
    MODE_MIDDLE  = 3'd4
  } mode_e;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_ALLIANCE_BLUE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SORT_ENABLE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROX_THRESH   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COUNTER_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_LEVEL    = 3'd5;

  localparam logic [7:0] RST_PROX_THRESH   = 8'd35;
  localparam logic [3:0] RST_SAMPLE_PERIOD = 4'd3;
  localparam logic [3:0] RST_COUNTER_LIMIT = 4'd10;
  localparam logic [3:0] RST_TRIP_LEVEL    = 4'd5;

  localparam logic [8:0] HUE_RED_LO  = 9'd300;
  localparam logic [8:0] HUE_RED_HI  = 9'd360;
  localparam logic [8:0] HUE_BLUE_LO = 9'd215;
  localparam logic [8:0] HUE_BLUE_HI = 9'd250;

  localparam logic [4:0] CNT_STEP_UP   = 5'd4;
  localparam logic [3:0] CNT_STEP_DOWN = 4'd3;

  localparam logic signed [7:0] SPEED_FULL     = 8'sd127;
  localparam logic signed [7:0] SPEED_HALF     = 8'sd64;
  localparam logic signed [7:0] SPEED_REV_MID  = 8'sd100;
  localparam logic signed [7:0] SPEED_FULL_REV = -8'sd127;
  localparam logic signed [7:0] SPEED_HALF_REV = -8'sd64;
  localparam logic signed [7:0] SPEED_ZERO     = 8'sd0;

  typedef struct packed {
    logic       button_high_goal;
    logic       button_middle_goal;
    logic       button_forward;
    logic       button_reverse;
    logic       autonomous;
    logic [7:0] proximity;
    logic [8:0] hue;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        intake_mode;
    logic signed [7:0] intake_speed;
    logic signed [7:0] middle_roller_speed;
    logic signed [7:0] top_roller_speed;
    logic              middle_goal_valve;
    logic              sensor_led_on;
  } out_word_t;

  typedef struct packed {
    logic       alliance_blue;
    logic       sort_enable;
    logic [7:0] proximity_threshold;
    logic [3:0] sample_period;
    logic [3:0] counter_limit;
    logic [3:0] trip_level;
  } cfg_t;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] prev_buttons;
    logic [3:0] sort_counter;
    logic [3:0] sample_phase;
    logic       led;
    logic       valve;
  } state_t;

  function automatic mode_e toggle_mode(input mode_e cur, input mode_e target);
    toggle_mode = (cur == target) ? MODE_OFF : target;
  endfunction

endpackage

/* rtl/imcs_step.sv */
// Next-state and result logic for one control tick of the intake controller.
module imcs_step import imcs_pkg::*; (
  input  cfg_t      cfg_i,
  input  state_t    state_i,
  input  in_word_t  word_i,
  output state_t    state_o,
  output out_word_t result_o
);

  logic [3:0] now;
  logic [3:0] rise;
  mode_e      m1, m2, m3, m4;
  logic [3:0] period;
  logic [4:0] phase_inc;
  logic       sample;
  logic       present;
  logic       opposite;
  logic [4:0] cnt_up;
  logic [3:0] cnt_rise;
  logic [3:0] cnt_fall;
  logic [3:0] cnt_next;
  logic       sorting;

  assign now  = {word_i.button_reverse, word_i.button_forward,
                 word_i.button_middle_goal, word_i.button_high_goal};
  assign rise = now & ~state_i.prev_buttons;

  assign m1 = rise[0] ? toggle_mode(state_i.mode, MODE_HIGH) : state_i.mode;
  assign m2 = rise[1] ? toggle_mode(m1, MODE_MIDDLE) : m1;
  assign m3 = rise[2] ? toggle_mode(m2, MODE_FORWARD) : m2;
  assign m4 = rise[3] ? toggle_mode(m3, MODE_REVERSE) : m3;

  assign period    = (cfg_i.sample_period == 4'd0) ? 4'd1 : cfg_i.sample_period;
  assign sample    = (state_i.sample_phase == 4'd0);
  assign phase_inc = {1'b0, state_i.sample_phase} + 5'd1;

  assign present = word_i.proximity > cfg_i.proximity_threshold;

  always_comb begin
    if (!present) begin
      opposite = 1'b0;
    end else if (word_i.hue >= HUE_RED_LO && word_i.hue <= HUE_RED_HI) begin
      opposite = cfg_i.alliance_blue;
    end else if (word_i.hue >= HUE_BLUE_LO && word_i.hue <= HUE_BLUE_HI) begin
      opposite = ~cfg_i.alliance_blue;
    end else begin
      opposite = 1'b0;
    end
  end

  assign cnt_up   = {1'b0, state_i.sort_counter} + CNT_STEP_UP;
  assign cnt_rise = (cnt_up < {1'b0, cfg_i.counter_limit}) ? cnt_up[3:0]
                                                           : cfg_i.counter_limit;
  assign cnt_fall = (state_i.sort_counter > CNT_STEP_DOWN)
                    ? state_i.sort_counter - CNT_STEP_DOWN : 4'd0;

  assign sorting = cfg_i.sort_enable && (m4 == MODE_FORWARD);

  always_comb begin
    if (!sorting) begin
      cnt_next = 4'd0;
    end else if (sample) begin
      cnt_next = opposite ? cnt_rise : cnt_fall;
    end else begin
      cnt_next = state_i.sort_counter;
    end
  end

  always_comb begin
    state_o.mode         = m4;
    state_o.prev_buttons = now;
    state_o.sort_counter = cnt_next;
    state_o.sample_phase = (phase_inc >= {1'b0, period}) ? 4'd0 : phase_inc[3:0];
    state_o.led          = sorting;
    state_o.valve        = state_i.valve;

    result_o.intake_mode         = m4;
    result_o.intake_speed        = SPEED_ZERO;
    result_o.middle_roller_speed = SPEED_ZERO;
    result_o.top_roller_speed    = SPEED_ZERO;

    unique case (m4)
      MODE_FORWARD: begin
        state_o.valve                = 1'b0;
        result_o.intake_speed        = SPEED_FULL;
        result_o.middle_roller_speed = SPEED_HALF;
        result_o.top_roller_speed    = (cnt_next >= cfg_i.trip_level) ? SPEED_FULL
                                                                      : SPEED_ZERO;
      end
      MODE_REVERSE: begin
        state_o.valve                = 1'b0;
        result_o.intake_speed        = SPEED_FULL_REV;
        result_o.middle_roller_speed = SPEED_REV_MID;
        result_o.top_roller_speed    = SPEED_HALF_REV;
      end
      MODE_HIGH: begin
        state_o.valve                = 1'b0;
        result_o.intake_speed        = SPEED_FULL;
        result_o.middle_roller_speed = SPEED_FULL;
        result_o.top_roller_speed    = SPEED_FULL;
      end
      MODE_MIDDLE: begin
        state_o.valve                = 1'b1;
        result_o.intake_speed        = SPEED_FULL;
        result_o.middle_roller_speed = SPEED_FULL;
        result_o.top_roller_speed    = SPEED_FULL;
      end
      default: begin
      end
    endcase

    result_o.middle_goal_valve = state_o.valve;
    result_o.sensor_led_on     = state_o.led;
  end

endmodule

/* rtl/intake_mode_color_sort_controller_unit.sv */
// Top level of the intake mode and color sort controller with its register file and output buffer.
// A result is registered in the output register, or in the skid entry while the output register is held.
// Throughput: one word per cycle while in_stall_o is low; the state update in imcs_step is combinational.
// A two-entry output buffer lets words keep arriving while a result waits downstream.
// Reset clears the mode, button history, counter, phase, LED, valve and buffer state,
// and loads the register defaults.
module intake_mode_color_sort_controller_unit import imcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  out_word_t result;
  out_word_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_take, produce, out_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_take     = in_valid_i && !skid_valid_q;
  assign produce     = in_take && !in_word_i.autonomous;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  imcs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .word_i   (in_word_i),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alliance_blue       <= 1'b0;
      cfg_q.sort_enable         <= 1'b1;
      cfg_q.proximity_threshold <= RST_PROX_THRESH;
      cfg_q.sample_period       <= RST_SAMPLE_PERIOD;
      cfg_q.counter_limit       <= RST_COUNTER_LIMIT;
      cfg_q.trip_level          <= RST_TRIP_LEVEL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALLIANCE_BLUE: cfg_q.alliance_blue       <= cfg_data_i[0];
        CFG_SORT_ENABLE:   cfg_q.sort_enable         <= cfg_data_i[0];
        CFG_PROX_THRESH:   cfg_q.proximity_threshold <= cfg_data_i;
        CFG_SAMPLE_PERIOD: cfg_q.sample_period       <= cfg_data_i[3:0];
        CFG_COUNTER_LIMIT: cfg_q.counter_limit       <= cfg_data_i[3:0];
        CFG_TRIP_LEVEL:    cfg_q.trip_level          <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= MODE_OFF;
      state_q.prev_buttons <= 4'd0;
      state_q.sort_counter <= 4'd0;
      state_q.sample_phase <= 4'd0;
      state_q.led          <= 1'b0;
      state_q.valve        <= 1'b0;
    end else if (produce) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (produce) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (produce) begin
      if (out_valid_q && !out_take) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

endmodule

/* test/tb.sv */
// Self-checking testbench for the intake mode and color sort controller.
module tb;
  import imcs_pkg::*;

  class sort_scoreboard;
    out_word_t pending_q[$];
    int errors;
    logic alliance_blue, sort_en;
    logic [7:0] prox_thr;
    logic [3:0] period_r, limit_r, trip_r;
    mode_e mode;
    logic [3:0] prev_btn, counter, phase;
    logic led, valve;

    function new();
      errors = 0;
      alliance_blue = 1'b0;
      sort_en = 1'b1;
      prox_thr = RST_PROX_THRESH;
      period_r = RST_SAMPLE_PERIOD;
      limit_r = RST_COUNTER_LIMIT;
      trip_r = RST_TRIP_LEVEL;
      mode = MODE_OFF;
      prev_btn = '0;
      counter = '0;
      phase = '0;
      led = 1'b0;
      valve = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] d);
      case (idx)
        CFG_ALLIANCE_BLUE: alliance_blue = d[0];
        CFG_SORT_ENABLE:   sort_en = d[0];
        CFG_PROX_THRESH:   prox_thr = d;
        CFG_SAMPLE_PERIOD: period_r = d[3:0];
        CFG_COUNTER_LIMIT: limit_r = d[3:0];
        CFG_TRIP_LEVEL:    trip_r = d[3:0];
        default: ;
      endcase
    endfunction

    function mode_e flip_mode(mode_e cur, mode_e target);
      return (cur == target) ? MODE_OFF : target;
    endfunction

    function void note_tick(in_word_t w);
      logic [3:0] now, rise;
      logic [4:0] per, nxt, up;
      logic smp, opp;
      mode_e m;
      out_word_t r;
      if (w.autonomous) return;
      now = {w.button_reverse, w.button_forward, w.button_middle_goal, w.button_high_goal};
      rise = now & ~prev_btn;
      prev_btn = now;
      m = mode;
      if (rise[0]) m = flip_mode(m, MODE_HIGH);
      if (rise[1]) m = flip_mode(m, MODE_MIDDLE);
      if (rise[2]) m = flip_mode(m, MODE_FORWARD);
      if (rise[3]) m = flip_mode(m, MODE_REVERSE);
      mode = m;
      per = (period_r == 4'd0) ? 5'd1 : {1'b0, period_r};
      smp = (phase == 4'd0);
      nxt = {1'b0, phase} + 5'd1;
      phase = (nxt >= per) ? 4'd0 : nxt[3:0];
      if (sort_en && m == MODE_FORWARD) begin
        led = 1'b1;
        if (smp) begin
          opp = 1'b0;
          if (w.proximity > prox_thr) begin
            if (w.hue >= HUE_RED_LO && w.hue <= HUE_RED_HI) opp = alliance_blue;
            else if (w.hue >= HUE_BLUE_LO && w.hue <= HUE_BLUE_HI) opp = !alliance_blue;
          end
          if (opp) begin
            up = {1'b0, counter} + 5'd4;
            counter = (up < {1'b0, limit_r}) ? up[3:0] : limit_r;
          end else begin
            counter = (counter > 4'd3) ? counter - 4'd3 : 4'd0;
          end
        end
      end else begin
        led = 1'b0;
        counter = 4'd0;
      end
      r = '0;
      r.intake_mode = m;
      case (m)
        MODE_FORWARD: begin
          valve = 1'b0;
          r.intake_speed = SPEED_FULL;
          r.middle_roller_speed = SPEED_HALF;
          r.top_roller_speed = (counter >= trip_r) ? SPEED_FULL : SPEED_ZERO;
        end
        MODE_REVERSE: begin
          valve = 1'b0;
          r.intake_speed = SPEED_FULL_REV;
          r.middle_roller_speed = SPEED_REV_MID;
          r.top_roller_speed = SPEED_HALF_REV;
        end
        MODE_HIGH, MODE_MIDDLE: begin
          valve = (m == MODE_MIDDLE);
          r.intake_speed = SPEED_FULL;
          r.middle_roller_speed = SPEED_FULL;
          r.top_roller_speed = SPEED_FULL;
        end
        default: ;
      endcase
      r.middle_goal_valve = valve;
      r.sensor_led_on = led;
      pending_q.push_back(r);
    endfunction

    function void cmp_field(string f, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, f, e, a);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      e = pending_q.pop_front();
      cmp_field("intake_mode", e.intake_mode, got.intake_mode);
      cmp_field("intake_speed", e.intake_speed, got.intake_speed);
      cmp_field("middle_roller_speed", e.middle_roller_speed, got.middle_roller_speed);
      cmp_field("top_roller_speed", e.top_roller_speed, got.top_roller_speed);
      cmp_field("middle_goal_valve", e.middle_goal_valve, got.middle_goal_valve);
      cmp_field("sensor_led_on", e.sensor_led_on, got.sensor_led_on);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_word_t in_word = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_word_t out_word_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  sort_scoreboard sb = new();
  int in_gap_pct = 30;
  int out_stall_pct = 30;
  int hold_req = 0;

  intake_mode_color_sort_controller_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[intake_mode_color_sort_controller_unit] ERROR");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall) sb.check_result(out_word_o);
      if (hold_req != 0) begin
        hold_req = 0;
        stall_left = 150;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(99) < out_stall_pct) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(1, 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_word_t mk(logic [3:0] b, logic auto, logic [7:0] prox, logic [8:0] hue);
    in_word_t w;
    w = '0;
    w.button_high_goal = b[3];
    w.button_middle_goal = b[2];
    w.button_forward = b[1];
    w.button_reverse = b[0];
    w.autonomous = auto;
    w.proximity = prox;
    w.hue = hue;
    return w;
  endfunction

  function automatic in_word_t rand_tick();
    in_word_t w;
    logic [8:0] edge_hues [8];
    logic [7:0] prox;
    logic [8:0] hue;
    edge_hues = '{9'd214, 9'd215, 9'd250, 9'd251, 9'd299, 9'd300, 9'd360, 9'd361};
    if ($urandom_range(99) < 8) begin
      w = in_word_t'($urandom);
      return w;
    end
    case ($urandom_range(3))
      0: hue = 9'($urandom_range(360, 300));
      1: hue = 9'($urandom_range(250, 215));
      2: hue = 9'($urandom_range(511));
      default: hue = edge_hues[$urandom_range(7)];
    endcase
    if ($urandom_range(1) == 0) prox = 8'($urandom_range(255));
    else prox = sb.prox_thr + 8'($urandom_range(2)) - 8'd1;
    w = mk({$urandom_range(99) < 2, $urandom_range(99) < 2,
            $urandom_range(99) < 6, $urandom_range(99) < 2},
           $urandom_range(99) < 5, prox, hue);
    return w;
  endfunction

  task automatic send_tick(input in_word_t w);
    int gap;
    if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_ALLIANCE_BLUE, {7'd0, c.alliance_blue});
    write_reg(CFG_SORT_ENABLE, {7'd0, c.sort_enable});
    write_reg(CFG_PROX_THRESH, c.proximity_threshold);
    write_reg(CFG_SAMPLE_PERIOD, {4'd0, c.sample_period});
    write_reg(CFG_COUNTER_LIMIT, {4'd0, c.counter_limit});
    write_reg(CFG_TRIP_LEVEL, {4'd0, c.trip_level});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_word_t directed [$];
    cfg_t plan [7];
    plan[0] = '{1'b0, 1'b1, 8'd35, 4'd3, 4'd10, 4'd5};
    plan[1] = '{1'b1, 1'b1, 8'd0, 4'd1, 4'd15, 4'd15};
    plan[2] = '{1'b0, 1'b0, 8'd255, 4'd15, 4'd0, 4'd0};
    plan[3] = '{1'b1, 1'b1, 8'd128, 4'd0, 4'd7, 4'd4};
    plan[4] = '{1'b0, 1'b1, 8'd35, 4'd2, 4'd3, 4'd3};
    plan[5] = '{1'b0, 1'b1, 8'd10, 4'd5, 4'd15, 4'd8};
    plan[6] = '{1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed = '{mk(4'b0010, 1'b1, 8'd255, 9'd230), mk(4'b0010, 1'b0, 8'd255, 9'd230),
                 mk(4'b0010, 1'b0, 8'd36, 9'd215), mk(4'b0010, 1'b0, 8'd36, 9'd215),
                 mk(4'b0010, 1'b0, 8'd36, 9'd215), mk(4'b0010, 1'b0, 8'd35, 9'd250),
                 mk(4'b0010, 1'b0, 8'd35, 9'd250), mk(4'b0010, 1'b0, 8'd35, 9'd250),
                 mk(4'b0010, 1'b0, 8'd255, 9'd250), mk(4'b0010, 1'b0, 8'd255, 9'd250),
                 mk(4'b0010, 1'b0, 8'd255, 9'd250), mk(4'b0010, 1'b0, 8'd255, 9'd360),
                 mk(4'b0010, 1'b0, 8'd255, 9'd511), mk(4'b0010, 1'b0, 8'd255, 9'd361),
                 mk(4'b1111, 1'b0, 8'd0, 9'd0), mk(4'b0000, 1'b0, 8'd0, 9'd0),
                 mk(4'b0100, 1'b0, 8'd0, 9'd0), mk(4'b0000, 1'b0, 8'd0, 9'd0),
                 mk(4'b0100, 1'b0, 8'd0, 9'd0), mk(4'b0000, 1'b0, 8'd0, 9'd0),
                 mk(4'b1000, 1'b0, 8'd0, 9'd0), mk(4'b0001, 1'b0, 8'd0, 9'd0),
                 mk(4'b0000, 1'b1, 8'd0, 9'd0), mk(4'b1111, 1'b0, 8'd255, 9'd511)};
    foreach (directed[i]) send_tick(directed[i]);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        drain_results();
        apply_settings(plan[p]);
      end
      in_gap_pct = (p == 1) ? 0 : 30;
      out_stall_pct = (p == 1) ? 0 : 30;
      for (int k = 0; k < 100; k++) begin
        if (p == 5 && k == 20) begin
          hold_req = 1;
          in_gap_pct = 0;
        end
        if (p == 5 && k == 60) in_gap_pct = 30;
        if (p == 3 && k == 50) drain_results();
        send_tick(rand_tick());
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[intake_mode_color_sort_controller_unit] OK");
    end else begin
      $display("[intake_mode_color_sort_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/imcs_pkg.sv
rtl/imcs_step.sv
rtl/intake_mode_color_sort_controller_unit.sv
test/tb.sv
